/* sv/nbt_pkg.sv */
// shared types, constants and helper functions for the nbt tag skipper
`timescale 1ns / 1ps
`default_nettype none

package nbt_pkg;

    // depth stack geometry
    localparam int STACK_DEPTH = 512;
    localparam int DP_W        = $clog2(STACK_DEPTH);
    localparam int BANK_DEPTH  = (STACK_DEPTH + 1) / 2;
    localparam int BANK_AW     = DP_W - 1;

    // byte counts
    localparam int SKIP_W  = 34;
    localparam int COUNT_W = 32;

    // tag type codes
    localparam logic [3:0] TAG_END        = 4'd0;
    localparam logic [3:0] TAG_BYTE       = 4'd1;
    localparam logic [3:0] TAG_SHORT      = 4'd2;
    localparam logic [3:0] TAG_INT        = 4'd3;
    localparam logic [3:0] TAG_LONG       = 4'd4;
    localparam logic [3:0] TAG_FLOAT      = 4'd5;
    localparam logic [3:0] TAG_DOUBLE     = 4'd6;
    localparam logic [3:0] TAG_BYTE_ARRAY = 4'd7;
    localparam logic [3:0] TAG_STRING     = 4'd8;
    localparam logic [3:0] TAG_LIST       = 4'd9;
    localparam logic [3:0] TAG_COMPOUND   = 4'd10;
    localparam logic [3:0] TAG_INT_ARRAY  = 4'd11;
    localparam logic [3:0] TAG_LONG_ARRAY = 4'd12;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_BAD_TYPE  = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_NEG_COUNT = 2'd3
    } status_t;

    typedef enum logic [7:0] {
        PH_TYPE    = 8'b0000_0001,
        PH_NAMELEN = 8'b0000_0010,
        PH_NAME    = 8'b0000_0100,
        PH_SKIP    = 8'b0000_1000,
        PH_STRLEN  = 8'b0001_0000,
        PH_ARRCNT  = 8'b0010_0000,
        PH_LTYPE   = 8'b0100_0000,
        PH_LCNT    = 8'b1000_0000
    } phase_t;

    // one depth level: list element type and elements still to open
    typedef struct packed {
        logic [3:0]  elem_type;
        logic [30:0] remaining;
    } stack_entry_t;

    typedef struct packed {
        logic                valid;
        status_t             status;
        logic [COUNT_W-1:0]  length;
    } nbt_result_t;

    // log2 of the payload size of a fixed-size number
    function automatic logic [1:0] fixed_shift(input logic [3:0] t);
        logic [1:0] s;
        case (t) inside
            TAG_SHORT:             s = 2'd1;
            TAG_INT, TAG_FLOAT:    s = 2'd2;
            TAG_LONG, TAG_DOUBLE:  s = 2'd3;
            default:               s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic logic is_fixed(input logic [3:0] t);
        logic f;
        case (t) inside
            TAG_BYTE, TAG_SHORT, TAG_INT, TAG_LONG, TAG_FLOAT, TAG_DOUBLE: f = 1'b1;
            default: f = 1'b0;
        endcase
        return f;
    endfunction

    // log2 of the element size of an array tag
    function automatic logic [1:0] array_shift(input logic [3:0] t);
        logic [1:0] s;
        case (t) inside
            TAG_INT_ARRAY:  s = 2'd2;
            TAG_LONG_ARRAY: s = 2'd3;
            default:        s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* sv/nbt_ram.sv */
// generic simple dual port ram with registered write-first read
`timescale 1ns / 1ps
`default_nettype none

module nbt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 35,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/nbt_parser.sv */
// parse state, one-byte step logic and the banked depth stack
`timescale 1ns / 1ps
`default_nettype none

module nbt_parser
    import nbt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire logic [7:0]  step_byte,
    input  wire logic        step_restart,
    output nbt_result_t      result
);

    phase_t              phase_reg, phase_next;
    logic [3:0]          cur_type_reg, cur_type_next;
    logic [31:0]         field_reg, field_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic [DP_W-1:0]     depth_reg, depth_next;
    stack_entry_t        top_reg, top_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // even levels in bank 0, odd levels in bank 1
    logic                bank_we    [2];
    logic [BANK_AW-1:0]  bank_waddr [2];
    stack_entry_t        bank_wdata [2];
    logic [BANK_AW-1:0]  bank_raddr [2];
    stack_entry_t        bank_rdata [2];

    // prefetched levels depth-1 and depth-2
    stack_entry_t        below1, below2;

    assign below1 = depth_reg[0] ? bank_rdata[0] : bank_rdata[1];
    assign below2 = depth_reg[0] ? bank_rdata[1] : bank_rdata[0];

    always_comb begin
        phase_t             ph;
        logic [3:0]         ct;
        logic [31:0]        fs;
        logic [SKIP_W-1:0]  sk;
        logic [DP_W-1:0]    dp;
        logic [COUNT_W-1:0] cnt;
        stack_entry_t       top, below, under;
        logic               fin, ed, bp;
        status_t            code;
        logic [3:0]         bpt;
        logic               wa_en, wb_en;
        logic [DP_W-1:0]    wa_lvl, wb_lvl;
        stack_entry_t       wa_data, wb_data;
        logic [SKIP_W-1:0]  prod;
        logic [DP_W-1:0]    rl1, rl2;

        ph      = phase_reg;
        ct      = cur_type_reg;
        fs      = field_reg;
        sk      = skip_reg;
        dp      = depth_reg;
        cnt     = count_reg;
        top     = top_reg;
        below   = below1;
        under   = below2;
        fin     = 1'b0;
        ed      = 1'b0;
        bp      = 1'b0;
        code    = ST_DONE;
        bpt     = cur_type_reg;
        wa_en   = 1'b0;
        wb_en   = 1'b0;
        wa_lvl  = depth_reg;
        wb_lvl  = depth_reg;
        wa_data = top_reg;
        wb_data = top_reg;
        prod    = '0;

        if (step_en) begin
            if (step_restart) begin
                ph  = PH_TYPE;
                dp  = '0;
                cnt = '0;
                fs  = '0;
                sk  = '0;
            end
            if (cnt != '1) begin
                cnt = cnt + COUNT_W'(1);
            end

            case (ph)
                PH_TYPE: begin
                    if (step_byte == {4'd0, TAG_END}) begin
                        if (dp == '0) begin
                            fin  = 1'b1;
                            code = ST_DONE;
                        end else begin
                            // close one compound
                            dp    = dp - DP_W'(1);
                            top   = below;
                            below = under;
                            ed    = 1'b1;
                        end
                    end else if (step_byte > {4'd0, TAG_LONG_ARRAY}) begin
                        fin  = 1'b1;
                        code = ST_BAD_TYPE;
                    end else begin
                        ct = step_byte[3:0];
                        ph = PH_NAMELEN;
                        sk = SKIP_W'(2);
                        fs = '0;
                    end
                end
                PH_NAME: begin
                    sk = sk - SKIP_W'(1);
                    if (sk == '0) begin
                        bp  = 1'b1;
                        bpt = ct;
                    end
                end
                PH_SKIP: begin
                    sk = sk - SKIP_W'(1);
                    if (sk == '0) begin
                        ed = 1'b1;
                    end
                end
                PH_LTYPE: begin
                    if (step_byte > {4'd0, TAG_LONG_ARRAY}) begin
                        fin  = 1'b1;
                        code = ST_BAD_TYPE;
                    end else begin
                        ct = step_byte[3:0];
                        ph = PH_LCNT;
                        sk = SKIP_W'(4);
                        fs = '0;
                    end
                end
                default: begin
                    // big-endian length and count fields
                    fs = {fs[23:0], step_byte};
                    sk = sk - SKIP_W'(1);
                    if (sk == '0) begin
                        case (ph)
                            PH_NAMELEN: begin
                                if (fs[15:0] == '0) begin
                                    bp  = 1'b1;
                                    bpt = ct;
                                end else begin
                                    ph = PH_NAME;
                                    sk = SKIP_W'(fs[15:0]);
                                end
                            end
                            PH_STRLEN: begin
                                if (fs[15:0] == '0) begin
                                    ed = 1'b1;
                                end else begin
                                    ph = PH_SKIP;
                                    sk = SKIP_W'(fs[15:0]);
                                end
                            end
                            PH_ARRCNT: begin
                                if (fs[31]) begin
                                    fin  = 1'b1;
                                    code = ST_NEG_COUNT;
                                end else begin
                                    prod = {3'b000, fs[30:0]} << array_shift(ct);
                                    if (prod == '0) begin
                                        ed = 1'b1;
                                    end else begin
                                        ph = PH_SKIP;
                                        sk = prod;
                                    end
                                end
                            end
                            PH_LCNT: begin
                                if (fs[31]) begin
                                    fin  = 1'b1;
                                    code = ST_NEG_COUNT;
                                end else if ((ct == TAG_END) || (fs == '0)) begin
                                    ed = 1'b1;
                                end else if (is_fixed(ct)) begin
                                    // primitive list skipped whole
                                    prod = {3'b000, fs[30:0]} << fixed_shift(ct);
                                    ph   = PH_SKIP;
                                    sk   = prod;
                                end else if (dp == DP_W'(STACK_DEPTH - 1)) begin
                                    fin  = 1'b1;
                                    code = ST_OVERFLOW;
                                end else begin
                                    // push the list level
                                    wa_en         = 1'b1;
                                    wa_lvl        = dp;
                                    wa_data       = top;
                                    below         = top;
                                    dp            = dp + DP_W'(1);
                                    top.elem_type = ct;
                                    top.remaining = fs[30:0];
                                    ed            = 1'b1;
                                end
                            end
                            default: begin
                                ph = PH_TYPE;
                            end
                        endcase
                    end
                end
            endcase

            // one element of the current level is finished
            if (ed && !fin) begin
                if (dp == '0) begin
                    fin  = 1'b1;
                    code = ST_DONE;
                end else if (top.remaining != '0) begin
                    bpt           = top.elem_type;
                    top.remaining = top.remaining - 31'd1;
                    bp            = 1'b1;
                    if (top.remaining == '0) begin
                        // last list element opens: leave the list level
                        dp    = dp - DP_W'(1);
                        top   = below;
                        wa_en = 1'b0;
                    end
                end else begin
                    ph = PH_TYPE;
                end
            end

            // start a payload of type bpt
            if (bp && !fin) begin
                ct = bpt;
                case (bpt) inside
                    TAG_BYTE, TAG_SHORT, TAG_INT, TAG_LONG, TAG_FLOAT, TAG_DOUBLE: begin
                        ph = PH_SKIP;
                        sk = SKIP_W'(1) << fixed_shift(bpt);
                    end
                    TAG_BYTE_ARRAY, TAG_INT_ARRAY, TAG_LONG_ARRAY: begin
                        ph = PH_ARRCNT;
                        sk = SKIP_W'(4);
                        fs = '0;
                    end
                    TAG_STRING: begin
                        ph = PH_STRLEN;
                        sk = SKIP_W'(2);
                        fs = '0;
                    end
                    TAG_LIST: begin
                        ph = PH_LTYPE;
                    end
                    TAG_COMPOUND: begin
                        if (dp == DP_W'(STACK_DEPTH - 1)) begin
                            fin  = 1'b1;
                            code = ST_OVERFLOW;
                        end else begin
                            wb_en         = 1'b1;
                            wb_lvl        = dp;
                            wb_data       = top;
                            dp            = dp + DP_W'(1);
                            top.elem_type = bpt;
                            top.remaining = '0;
                            ph            = PH_TYPE;
                        end
                    end
                    default: begin
                        fin  = 1'b1;
                        code = ST_BAD_TYPE;
                    end
                endcase
            end

            if (fin) begin
                ph = PH_TYPE;
                dp = '0;
                fs = '0;
                sk = '0;
            end
        end

        result.valid  = fin;
        result.status = code;
        result.length = cnt;

        phase_next    = ph;
        cur_type_next = ct;
        field_next    = fs;
        skip_next     = sk;
        depth_next    = dp;
        top_next      = top;
        count_next    = fin ? '0 : cnt;

        // at most one write per bank: a list push and a compound push land on
        // neighboring levels; the later write wins on a shared bank
        rl1 = dp - DP_W'(1);
        rl2 = dp - DP_W'(2);
        for (int k = 0; k < 2; k++) begin
            bank_we[k]    = wa_en && (wa_lvl[0] == 1'(k));
            bank_waddr[k] = wa_lvl[DP_W-1:1];
            bank_wdata[k] = wa_data;
            if (wb_en && (wb_lvl[0] == 1'(k))) begin
                bank_we[k]    = 1'b1;
                bank_waddr[k] = wb_lvl[DP_W-1:1];
                bank_wdata[k] = wb_data;
            end
            bank_raddr[k] = (rl1[0] == 1'(k)) ? rl1[DP_W-1:1] : rl2[DP_W-1:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TYPE;
            cur_type_reg <= TAG_END;
            field_reg    <= '0;
            skip_reg     <= '0;
            depth_reg    <= '0;
            count_reg    <= '0;
        end else begin
            phase_reg    <= phase_next;
            cur_type_reg <= cur_type_next;
            field_reg    <= field_next;
            skip_reg     <= skip_next;
            depth_reg    <= depth_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
    end

    for (genvar g = 0; g < 2; g++) begin : g_bank
        nbt_ram #(
            .DEPTH (BANK_DEPTH),
            .WIDTH ($bits(stack_entry_t))
        ) u_bank (
            .aclk    (aclk),
            .wr_en   (bank_we[g]),
            .wr_addr (bank_waddr[g]),
            .wr_data (bank_wdata[g]),
            .rd_addr (bank_raddr[g]),
            .rd_data (bank_rdata[g])
        );
    end

endmodule

`default_nettype wire

/* sv/nbt_tag_skipper.sv */
// top level: input register, parser step and result register
// path: an accepted item waits in the input register until the parser steps on it;
//   a result it causes is loaded into the result register that drives m_tvalid
// throughput: one byte per cycle, sustained while m_tready is high
// reset: synchronous, active low aresetn; clears both handshake registers and
//   the parse state; the stack memory is not cleared and needs no sweep
`timescale 1ns / 1ps
`default_nettype none

module nbt_tag_skipper
    import nbt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] restart
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] tag_length
    output logic [1:0]       m_tuser    // [1:0] status
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_restart_reg;

    // result register
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_length_reg;

    logic        step_ready;
    logic        step_en;
    nbt_result_t result;

    // a byte is parsed whenever the result register can take what it causes
    assign step_ready = !out_valid_reg || m_tready;
    assign step_en    = in_valid_reg && step_ready;
    assign s_tready   = !in_valid_reg || step_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser[0];
        end
    end

    nbt_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .step_byte    (in_byte_reg),
        .step_restart (in_restart_reg),
        .result       (result)
    );

    // result register, reloaded in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (result.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            out_status_reg <= result.status;
            out_length_reg <= result.length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_length_reg;
    assign m_tuser  = out_status_reg;

    // a new result only comes from a parsed byte
    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(step_en))
        else $error("result appeared without a parsed item");

    // a completed tag spans at least its type byte
    a_done_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_DONE) |-> (m_tdata != '0))
        else $error("completed tag with zero length");

    // a held input byte is not lost while the parser is stalled
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step_en |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input item dropped or changed");

    // the parser never reports while its result cannot be taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !result.valid)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking testbench for nbt_tag_skipper: byte-stream tags against a scoreboard model
`timescale 1ns / 1ps

module tb_top
    import nbt_pkg::*;
();

    // one byte of the tag stream as it travels on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } stream_byte_t;

    // tracks the parse of every accepted byte and holds the tag results still due
    class tag_end_scoreboard;
        phase_t      phase;
        logic [3:0]  cur_type;
        logic [31:0] field_acc;
        logic [35:0] bytes_left;
        int unsigned level;
        logic [3:0]  lvl_type  [STACK_DEPTH];
        logic [30:0] lvl_count [STACK_DEPTH];
        logic [31:0] tag_bytes;
        bit          has_outcome;
        status_t     outcome;
        status_t     tag_status_q [$];
        logic [31:0] tag_length_q [$];
        int          errors;
        int          checked;
        int          status_seen [4];

        function new();
            phase       = PH_TYPE;
            cur_type    = TAG_END;
            field_acc   = '0;
            bytes_left  = '0;
            level       = 0;
            tag_bytes   = '0;
            has_outcome = 1'b0;
            errors      = 0;
            checked     = 0;
            foreach (lvl_type[i]) begin
                lvl_type[i]  = TAG_END;
                lvl_count[i] = '0;
            end
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // payload bytes of a fixed-size number, zero for all other types
        static function int number_bytes(input logic [3:0] t);
            case (t)
                TAG_BYTE:             return 1;
                TAG_SHORT:            return 2;
                TAG_INT, TAG_FLOAT:   return 4;
                TAG_LONG, TAG_DOUBLE: return 8;
                default:              return 0;
            endcase
        endfunction

        static function int elem_bytes(input logic [3:0] t);
            if (t == TAG_INT_ARRAY) return 4;
            if (t == TAG_LONG_ARRAY) return 8;
            return 1;
        endfunction

        function void close_tag(input status_t s);
            has_outcome = 1'b1;
            outcome     = s;
            phase       = PH_TYPE;
            level       = 0;
            field_acc   = '0;
            bytes_left  = '0;
        endfunction

        function void start_field(input phase_t p, input int n);
            phase      = p;
            bytes_left = 36'(n);
            field_acc  = '0;
        endfunction

        function void open_payload(input logic [3:0] t);
            int n;
            n = number_bytes(t);
            cur_type = t;
            if (n != 0) begin
                phase      = PH_SKIP;
                bytes_left = 36'(n);
                return;
            end
            case (t)
                TAG_BYTE_ARRAY, TAG_INT_ARRAY, TAG_LONG_ARRAY: start_field(PH_ARRCNT, 4);
                TAG_STRING: start_field(PH_STRLEN, 2);
                TAG_LIST: phase = PH_LTYPE;
                TAG_COMPOUND: begin
                    if (level + 1 >= STACK_DEPTH) begin
                        close_tag(ST_OVERFLOW);
                    end else begin
                        level++;
                        lvl_count[level] = '0;
                        phase = PH_TYPE;
                    end
                end
                default: close_tag(ST_BAD_TYPE);
            endcase
        endfunction

        // one element or named tag finished: open the next list element or go back to tags
        function void element_done();
            logic [3:0] t;
            if (level == 0) begin
                close_tag(ST_DONE);
                return;
            end
            if (lvl_count[level] != 0) begin
                t = lvl_type[level];
                lvl_count[level]--;
                if (lvl_count[level] == 0) level--;
                open_payload(t);
            end else begin
                phase = PH_TYPE;
            end
        endfunction

        function void skip_or_done(input logic [35:0] n);
            if (n == 0) begin
                element_done();
            end else begin
                phase      = PH_SKIP;
                bytes_left = n;
            end
        endfunction

        function void list_counted(input logic [31:0] cnt);
            logic [35:0] total;
            if (cnt[31]) begin
                close_tag(ST_NEG_COUNT);
                return;
            end
            if (cur_type == TAG_END || cnt == 0) begin
                element_done();
                return;
            end
            if (number_bytes(cur_type) != 0) begin
                total = {4'd0, cnt};
                skip_or_done(total * 36'(number_bytes(cur_type)));
                return;
            end
            if (level + 1 >= STACK_DEPTH) begin
                close_tag(ST_OVERFLOW);
                return;
            end
            level++;
            lvl_type[level]  = cur_type;
            lvl_count[level] = cnt[30:0];
            element_done();
        endfunction

        function void take_byte(input logic [7:0] b);
            logic [35:0] total;
            case (phase)
                PH_TYPE: begin
                    if (b == {4'd0, TAG_END}) begin
                        if (level == 0) begin
                            close_tag(ST_DONE);
                        end else begin
                            level--;
                            element_done();
                        end
                    end else if (b > {4'd0, TAG_LONG_ARRAY}) begin
                        close_tag(ST_BAD_TYPE);
                    end else begin
                        cur_type = b[3:0];
                        start_field(PH_NAMELEN, 2);
                    end
                end
                PH_NAME: begin
                    bytes_left--;
                    if (bytes_left == 0) open_payload(cur_type);
                end
                PH_SKIP: begin
                    bytes_left--;
                    if (bytes_left == 0) element_done();
                end
                PH_LTYPE: begin
                    if (b > {4'd0, TAG_LONG_ARRAY}) begin
                        close_tag(ST_BAD_TYPE);
                    end else begin
                        cur_type = b[3:0];
                        start_field(PH_LCNT, 4);
                    end
                end
                default: begin
                    // big-endian length or count field
                    field_acc = {field_acc[23:0], b};
                    bytes_left--;
                    if (bytes_left == 0) begin
                        case (phase)
                            PH_NAMELEN: begin
                                if (field_acc[15:0] == 0) begin
                                    open_payload(cur_type);
                                end else begin
                                    phase      = PH_NAME;
                                    bytes_left = {20'd0, field_acc[15:0]};
                                end
                            end
                            PH_STRLEN: skip_or_done({20'd0, field_acc[15:0]});
                            PH_ARRCNT: begin
                                if (field_acc[31]) begin
                                    close_tag(ST_NEG_COUNT);
                                end else begin
                                    total = {4'd0, field_acc};
                                    skip_or_done(total * 36'(elem_bytes(cur_type)));
                                end
                            end
                            default: list_counted(field_acc);
                        endcase
                    end
                end
            endcase
        endfunction

        // accepted input byte: advance the parse and queue a tag result if one ends here
        function void note_byte(input logic [7:0] b, input logic restart);
            if (restart) begin
                phase      = PH_TYPE;
                level      = 0;
                tag_bytes  = '0;
                field_acc  = '0;
                bytes_left = '0;
            end
            if (tag_bytes != 32'hFFFF_FFFF) tag_bytes++;
            has_outcome = 1'b0;
            take_byte(b);
            if (has_outcome) begin
                tag_status_q.push_back(outcome);
                tag_length_q.push_back(tag_bytes);
                tag_bytes = '0;
            end
        endfunction

        task report_error(input string msg);
            errors++;
            $display("ERROR at %0t ns: %s", $time, msg);
        endtask

        task check_tag_result(input logic [1:0] st, input logic [31:0] len);
            status_t     exp_st;
            logic [31:0] exp_len;
            if (tag_status_q.size() == 0) begin
                report_error($sformatf("unexpected result: status %0d length %0d", st, len));
                return;
            end
            exp_st  = tag_status_q.pop_front();
            exp_len = tag_length_q.pop_front();
            if (st !== exp_st)
                report_error($sformatf("status %0d, expected %0d", st, exp_st));
            if (len !== exp_len)
                report_error($sformatf("tag length %0d, expected %0d", len, exp_len));
            checked++;
            status_seen[int'(exp_st)]++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    tag_end_scoreboard sb;
    stream_byte_t      tx_q [$];
    bit                next_restart = 1'b0;
    int                idle_pct     = 24;
    int                bytes_sent   = 0;

    nbt_tag_skipper u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side stalls at random, never during the calm stretch
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_tag_result(m_tuser, m_tdata);
    end

    // stream building: the first byte put after next_restart is set carries restart
    function automatic void put(input logic [7:0] d);
        tx_q.push_back('{data: d, restart: next_restart});
        next_restart = 1'b0;
    endfunction

    // a tag type code as one stream byte
    function automatic void put_tag(input logic [3:0] t);
        put({4'd0, t});
    endfunction

    function automatic void put_be(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) put(v[8*i +: 8]);
    endfunction

    // lists and compounds give way to an int array from the third level on
    function automatic logic [3:0] pick_type(input int lvl);
        logic [3:0] t;
        t = 4'($urandom_range(1, 12));
        if (lvl >= 3 && (t == TAG_LIST || t == TAG_COMPOUND)) t = TAG_INT_ARRAY;
        return t;
    endfunction

    function automatic logic [3:0] pick_array_type();
        case ($urandom_range(2))
            0:       return TAG_BYTE_ARRAY;
            1:       return TAG_INT_ARRAY;
            default: return TAG_LONG_ARRAY;
        endcase
    endfunction

    function automatic void put_payload(input logic [3:0] t, input int lvl);
        int         n;
        logic [3:0] et;
        case (t)
            TAG_BYTE_ARRAY, TAG_INT_ARRAY, TAG_LONG_ARRAY: begin
                n = $urandom_range(0, 4);
                put_be(n, 4);
                repeat (n * tag_end_scoreboard::elem_bytes(t)) put(8'($urandom));
            end
            TAG_STRING: begin
                n = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
                put_be(n, 2);
                repeat (n) put(8'($urandom));
            end
            TAG_LIST: begin
                et = 4'($urandom_range(0, 12));
                if (lvl >= 3 && (et == TAG_LIST || et == TAG_COMPOUND)) et = TAG_BYTE;
                n = $urandom_range(0, 3);
                put_tag(et);
                put_be(n, 4);
                // an end-typed list carries its count and nothing more
                if (et != TAG_END) repeat (n) put_payload(et, lvl + 1);
            end
            TAG_COMPOUND: begin
                repeat ($urandom_range(0, 2)) put_named(pick_type(lvl + 1), lvl + 1);
                put_tag(TAG_END);
            end
            default: repeat (tag_end_scoreboard::number_bytes(t)) put(8'($urandom));
        endcase
    endfunction

    function automatic void put_named(input logic [3:0] t, input int lvl);
        int n;
        n = $urandom_range(0, 4);
        put_tag(t);
        put_be(n, 2);
        repeat (n) put(8'($urandom));
        put_payload(t, lvl);
    endfunction

    task automatic send_item(input logic [7:0] d, input logic r);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= r;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(d, r);
        bytes_sent++;
    endtask

    task automatic send_all();
        stream_byte_t b;
        while (tx_q.size() != 0) begin
            b = tx_q.pop_front();
            send_item(b.data, b.restart);
        end
    endtask

    task automatic run_directed();
        // a lone end tag at top level is a whole tag
        put_tag(TAG_END);
        for (int t = TAG_BYTE; t <= TAG_LONG_ARRAY; t++) put_named(4'(t), 0);
        // unknown type bytes, including the top data value
        put(8'd13);
        put(8'hFF);
        // unknown list element type
        put_tag(TAG_LIST); put_be(0, 2); put(8'd200);
        // negative counts on an array and on a list
        put_tag(TAG_INT_ARRAY); put_be(0, 2); put_be(32'h8000_0000, 4);
        put_tag(TAG_LIST); put_be(0, 2); put_tag(TAG_COMPOUND); put_be(32'hFFFF_FFFF, 4);
        // empty list of compounds pushes nothing
        put_tag(TAG_LIST); put_be(1, 2); put(8'h41); put_tag(TAG_COMPOUND); put_be(0, 4);
        // end-typed list with a count but no elements
        put_tag(TAG_LIST); put_be(0, 2); put_tag(TAG_END); put_be(5, 4);
        // empty compound
        put_tag(TAG_COMPOUND); put_be(0, 2); put_tag(TAG_END);
        // list of two compounds, the first with a string inside
        put_tag(TAG_LIST); put_be(0, 2); put_tag(TAG_COMPOUND); put_be(2, 4);
        put_named(TAG_STRING, 1); put_tag(TAG_END);
        put_tag(TAG_END);
        // list of lists: a short list, then an end-typed one
        put_tag(TAG_LIST); put_be(0, 2); put_tag(TAG_LIST); put_be(2, 4);
        put_tag(TAG_SHORT); put_be(1, 4); put_be(32'h1234, 2);
        put_tag(TAG_END); put_be(3, 4);
        // longest name and string lengths, each cut short by a restart
        put_tag(TAG_BYTE); put_be(32'hFFFF, 2); repeat (5) put(8'($urandom));
        next_restart = 1'b1;
        put_tag(TAG_STRING); put_be(0, 2); put_be(32'hFFFF, 2); repeat (3) put(8'($urandom));
        // largest array and list counts, cut short the same way
        next_restart = 1'b1;
        put_tag(TAG_LONG_ARRAY); put_be(0, 2); put_be(32'h7FFF_FFFF, 4);
        repeat (4) put(8'($urandom));
        next_restart = 1'b1;
        put_tag(TAG_LIST); put_be(0, 2); put_tag(TAG_COMPOUND); put_be(32'h7FFF_FFFF, 4);
        put_named(TAG_INT, 1);
        next_restart = 1'b1;
        put_tag(TAG_BYTE); put_be(0, 2); put(8'h00);
        send_all();
    endtask

    task automatic run_random();
        int         start;
        int         cut;
        int         kind;
        logic [3:0] t;
        start = bytes_sent;
        while (bytes_sent - start < 1000) begin
            // calm stretch with no idling on either side
            idle_pct = (bytes_sent - start >= 400 && bytes_sent - start < 700) ? 0 : 24;
            kind = $urandom_range(99);
            if ($urandom_range(9) == 0) next_restart = 1'b1;
            if (kind < 62) begin
                if ($urandom_range(19) == 0) put_tag(TAG_END);
                else put_named(pick_type(0), 0);
            end else if (kind < 74) begin
                // well-formed tag cut off, the next one restarts
                put_named(pick_type(0), 0);
                if (tx_q.size() > 1) begin
                    cut = $urandom_range(1, tx_q.size() - 1);
                    while (tx_q.size() > cut) tx_q.pop_back();
                end
                next_restart = 1'b1;
            end else if (kind < 82) begin
                // large length or count fields, abandoned after a few bytes
                case ($urandom_range(3))
                    0: begin
                        put_tag(pick_type(0));
                        put_be($urandom_range(32'h100, 32'hFFFF), 2);
                    end
                    1: begin
                        put_tag(TAG_STRING); put_be(0, 2);
                        put_be($urandom_range(32'h100, 32'hFFFF), 2);
                    end
                    2: begin
                        put_tag(pick_array_type()); put_be(0, 2);
                        put_be($urandom >> 1, 4);
                    end
                    default: begin
                        put_tag(TAG_LIST); put_be(0, 2);
                        put_tag(pick_type(0)); put_be($urandom >> 1, 4);
                    end
                endcase
                repeat ($urandom_range(0, 6)) put(8'($urandom));
                next_restart = 1'b1;
            end else if (kind < 90) begin
                if ($urandom_range(1) == 0) begin
                    put_tag(pick_array_type()); put_be(0, 2);
                end else begin
                    put_tag(TAG_LIST); put_be(0, 2); put_tag(4'($urandom_range(0, 12)));
                end
                put_be({1'b1, 31'($urandom)}, 4);
            end else if (kind < 95) begin
                if ($urandom_range(1) == 0) begin
                    put(8'($urandom_range(13, 255)));
                end else begin
                    put_tag(TAG_LIST); put_be(0, 2); put(8'($urandom_range(13, 255)));
                end
            end else begin
                // raw noise with random restarts
                repeat ($urandom_range(1, 8)) begin
                    next_restart = 1'($urandom_range(1));
                    put(8'($urandom));
                end
                next_restart = 1'b1;
            end
            send_all();
        end
        idle_pct = 24;
    endtask

    initial begin
        int waited;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.tag_status_q.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (sb.tag_status_q.size() != 0)
            sb.report_error($sformatf("%0d tag results never arrived", sb.tag_status_q.size()));
        $display("streamed %0d bytes, checked %0d tag results", bytes_sent, sb.checked);
        $display("complete %0d, unknown type %0d, depth overflow %0d, negative count %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hard stop if the stream hangs
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
sv/nbt_pkg.sv
sv/nbt_ram.sv
sv/nbt_parser.sv
sv/nbt_tag_skipper.sv
bench/tb_top.sv
